// ===== sv/thcs_pkg.sv =====
package thcs_pkg;

  // Field and state widths
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int COOL_W = 20;
  localparam int LED_W  = 8;
  localparam int TONE_W = 12;
  localparam int PH_W   = 2;
  localparam int CFG_W  = 20;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 40;

  // Divider widths
  localparam int DIV_W   = 32;
  localparam int DIVR_W  = 16;
  localparam int DCNT_W  = $clog2(DIV_W);

  // Phase codes
  localparam logic [PH_W-1:0] PH_ARMED = 2'd0;
  localparam logic [PH_W-1:0] PH_HOLD  = 2'd1;
  localparam logic [PH_W-1:0] PH_COOL  = 2'd2;

  // Register indexes
  localparam logic CFG_HOLD = 1'b0;
  localparam logic CFG_COOL = 1'b1;

  // Divider operand selects
  localparam logic [1:0] SEL_RED_PER = 2'd0;
  localparam logic [1:0] SEL_RED_BRT = 2'd1;
  localparam logic [1:0] SEL_RED_MOD = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       pre;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_per;
    logic       cap_brt;
    logic       cap_mod;
    logic       fin;
    logic       load_out;
  } thcs_cmd_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            hold_zero;
    logic            div_done;
    logic            out_free;
  } thcs_sts_t;

endpackage

// ===== sv/thcs_div.sv =====
module thcs_div import thcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quot,
  output logic [DIVR_W-1:0] rem
);

  localparam logic [DCNT_W-1:0] LAST = DCNT_W'(DIV_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  quot_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] dsr_r;

  logic [DIVR_W:0]   part;
  logic [DIVR_W+1:0] diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit, try the subtract
  assign part = {rem_r, quot_r[DIV_W-1]};
  assign diff = {1'b0, part} - {2'b00, dsr_r};
  assign ge   = ~diff[DIVR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      quot_r <= '0;
      rem_r  <= '0;
      dsr_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quot_r <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        quot_r <= {quot_r[DIV_W-2:0], ge};
        rem_r  <= ge ? diff[DIVR_W-1:0] : part[DIVR_W-1:0];
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ===== sv/thcs_dp.sv =====
module thcs_dp import thcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  thcs_cmd_t        cmd,
  output thcs_sts_t        sts,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  // Configuration
  logic [HOLD_W-1:0] hold_r;
  logic [COOL_W-1:0] cool_r;

  // Tick state
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [TIME_W-1:0] pstart_r, pstart_nxt;
  logic [TONE_W-1:0] tone_r, tone_nxt;
  logic [TIME_W-1:0] tlast_r, tlast_nxt;
  logic [TIME_W-1:0] fdead_r, fdead_nxt;
  logic [LED_W-1:0]  grn_r, grn_nxt;
  logic [LED_W-1:0]  red_r, red_nxt;
  logic [LED_W-1:0]  yel_r, yel_nxt;
  logic [11:0]       gmod_r, gmod_nxt;

  // Latched beat
  logic              beam_r;
  logic [7:0]        lvl_r;
  logic [6:0]        dwell_r;
  logic [TONE_W-1:0] chat_r;
  logic [TONE_W-1:0] chat_in;

  // Divider results
  logic [8:0]        per_q_r;
  logic [7:0]        brt_q_r;
  logic [11:0]       mod_r;

  // Output register
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  logic [DIV_W-1:0]  div_dvd;
  logic [DIVR_W-1:0] div_dsr;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DIVR_W-1:0] div_rem;

  logic [TIME_W-1:0] e;
  logic [HOLD_W-1:0] c;
  logic [24:0]       prod_per;
  logic [24:0]       prod_brt;
  logic              hold_zero;
  logic [8:0]        period;
  logic [LED_W-1:0]  bright;
  logic [12:0]       rp1;
  logic [12:0]       on_lhs;
  logic [12:0]       on_rhs;
  logic [LED_W-1:0]  red_lvl;
  logic [LED_W-1:0]  grn_lvl;
  logic [13:0]       g3;
  logic [TIME_W-1:0] since;
  logic [12:0]       up7;
  logic [10:0]       dn_d;
  logic [12:0]       dn3;
  logic [TONE_W-1:0] tone_sched;
  logic [TIME_W-1:0] tlast_sched;

  // Clamp the chatter tone into its audible band
  always_comb begin
    chat_in = in_tdata[27:16];
    if (chat_in < 12'd400) begin
      chat_in = 12'd400;
    end else if (chat_in > 12'd2499) begin
      chat_in = 12'd2499;
    end
  end

  // Red ramp operands
  assign hold_zero = (hold_r == '0);
  assign e         = time_r - pstart_r;
  assign c         = (e > {{(TIME_W-HOLD_W){1'b0}}, hold_r}) ? hold_r : e[HOLD_W-1:0];
  assign prod_per  = {9'd0, c} * 25'd260;
  assign prod_brt  = {9'd0, c} * 25'd195;
  assign period    = hold_zero ? 9'd40 : 9'd300 - per_q_r;
  assign bright    = hold_zero ? 8'd255 : 8'd60 + brt_q_r;

  // Divider operand select
  always_comb begin
    unique case (cmd.div_sel)
      SEL_RED_PER: begin
        div_dvd = {7'd0, prod_per};
        div_dsr = hold_r;
      end
      SEL_RED_BRT: begin
        div_dvd = {7'd0, prod_brt};
        div_dsr = hold_r;
      end
      default: begin
        div_dvd = time_r;
        div_dsr = {7'd0, period};
      end
    endcase
  end

  thcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Red on while rem < floor(period*9/20), i.e. 20*(rem+1) <= 9*period
  assign rp1     = {4'd0, mod_r[8:0]} + 13'd1;
  assign on_lhs  = (rp1 << 4) + (rp1 << 2);
  assign on_rhs  = ({4'd0, period} << 3) + {4'd0, period};
  assign red_lvl = (on_lhs <= on_rhs) ? bright : '0;

  // Green triangle: slope 225/1200 is exactly 3/16, position from the tick counter
  always_comb begin
    if (gmod_r < 12'd1200) begin
      g3      = {2'd0, gmod_r} * 14'd3;
      grn_lvl = 8'd30 + g3[11:4];
    end else begin
      g3      = {2'd0, gmod_r - 12'd1200} * 14'd3;
      grn_lvl = 8'd255 - g3[11:4];
    end
  end

  // Hold tone schedule
  assign since = time_r - tlast_r;
  assign up7   = {3'd0, e[9:0]} * 13'd7;
  assign dn_d  = e[10:0] - 11'd800;
  assign dn3   = {2'd0, dn_d} * 13'd3;

  always_comb begin
    tone_sched  = tone_r;
    tlast_sched = tlast_r;
    if (e < 32'd800) begin
      tone_sched = 12'd400 + {1'b0, up7[12:2]};
    end else if (e < 32'd1600) begin
      tone_sched = 12'd1800 - dn3[12:1];
    end else if (e < 32'd3000) begin
      if (since >= 32'd6) begin
        tone_sched  = chat_r;
        tlast_sched = time_r;
      end
    end else if (e < 32'd4200) begin
      if (since >= 32'd40) begin
        tone_sched  = (tone_r == 12'd1400) ? 12'd1800 : 12'd1400;
        tlast_sched = time_r;
      end
    end else if (e < {{(TIME_W-HOLD_W){1'b0}}, hold_r}) begin
      tone_sched = 12'd1000;
    end else begin
      tone_sched = '0;
    end
  end

  // Next tick state
  always_comb begin
    time_nxt   = time_r;
    phase_nxt  = phase_r;
    pstart_nxt = pstart_r;
    tone_nxt   = tone_r;
    tlast_nxt  = tlast_r;
    fdead_nxt  = fdead_r;
    grn_nxt    = grn_r;
    red_nxt    = red_r;
    yel_nxt    = yel_r;
    gmod_nxt   = gmod_r;
    if (cmd.pre) begin
      if (phase_r == PH_ARMED && beam_r) begin
        phase_nxt  = PH_HOLD;
        pstart_nxt = time_r;
        tlast_nxt  = time_r;
        tone_nxt   = '0;
      end
    end
    if (cmd.fin) begin
      time_nxt = time_r + 1'b1;
      // Track time mod 2400; restart it where the tick time wraps to zero
      if (time_r == '1 || gmod_r == 12'd2399) begin
        gmod_nxt = '0;
      end else begin
        gmod_nxt = gmod_r + 12'd1;
      end
      unique case (phase_r)
        PH_HOLD: begin
          tone_nxt  = tone_sched;
          tlast_nxt = tlast_sched;
          red_nxt   = red_lvl;
          grn_nxt   = '0;
          yel_nxt   = '0;
          if (e >= {{(TIME_W-HOLD_W){1'b0}}, hold_r}) begin
            phase_nxt  = PH_COOL;
            pstart_nxt = time_r;
            tone_nxt   = '0;
          end
        end
        PH_COOL: begin
          if (time_r >= fdead_r) begin
            yel_nxt   = lvl_r;
            fdead_nxt = time_r + {25'd0, dwell_r};
          end
          grn_nxt = '0;
          red_nxt = '0;
          if (time_r - pstart_r >= {{(TIME_W-COOL_W){1'b0}}, cool_r}) begin
            phase_nxt = PH_ARMED;
          end
        end
        default: begin
          phase_nxt = PH_ARMED;
          grn_nxt   = grn_lvl;
          red_nxt   = '0;
          yel_nxt   = '0;
        end
      endcase
    end
  end

  // Hold configuration and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 16'd5000;
      cool_r   <= 20'd20000;
      time_r   <= '0;
      phase_r  <= PH_ARMED;
      pstart_r <= '0;
      tone_r   <= '0;
      tlast_r  <= '0;
      fdead_r  <= '0;
      grn_r    <= '0;
      red_r    <= '0;
      yel_r    <= '0;
      gmod_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_HOLD: hold_r <= cfg_data[HOLD_W-1:0];
          default:  cool_r <= cfg_data;
        endcase
      end
      time_r   <= time_nxt;
      phase_r  <= phase_nxt;
      pstart_r <= pstart_nxt;
      tone_r   <= tone_nxt;
      tlast_r  <= tlast_nxt;
      fdead_r  <= fdead_nxt;
      grn_r    <= grn_nxt;
      red_r    <= red_nxt;
      yel_r    <= yel_nxt;
      gmod_r   <= gmod_nxt;
    end
  end

  // Latch the input beat and capture divider results
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      beam_r  <= in_tdata[0];
      lvl_r   <= in_tdata[8:1];
      dwell_r <= in_tdata[15:9];
      chat_r  <= chat_in;
    end
    if (cmd.cap_per) begin
      per_q_r <= div_quot[8:0];
    end
    if (cmd.cap_brt) begin
      brt_q_r <= div_quot[7:0];
    end
    if (cmd.cap_mod) begin
      mod_r <= div_rem[11:0];
    end
  end

  // Output register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {1'b0, phase_r, tone_r, yel_r, red_r, grn_r, (phase_r == PH_HOLD)};
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = out_tdata_r;

  assign sts.phase     = phase_r;
  assign sts.hold_zero = hold_zero;
  assign sts.div_done  = div_done;
  assign sts.out_free  = ~out_tvalid_r | out_tready;

endmodule

// ===== sv/thcs_ctrl.sv =====
module thcs_ctrl import thcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  thcs_sts_t sts,
  output thcs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRE    = 3'd1;
  localparam logic [2:0] S_BRANCH = 3'd2;
  localparam logic [2:0] S_DPER   = 3'd3;
  localparam logic [2:0] S_DBRT   = 3'd4;
  localparam logic [2:0] S_DMOD   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Sequence one tick: arm check, divisions (hold phase only), state update, result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        unique case (sts.phase)
          PH_HOLD: begin
            cmd.div_start = 1'b1;
            if (sts.hold_zero) begin
              cmd.div_sel = SEL_RED_MOD;
              state_nxt   = S_DMOD;
            end else begin
              cmd.div_sel = SEL_RED_PER;
              state_nxt   = S_DPER;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DPER: begin
        if (sts.div_done) begin
          cmd.cap_per   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_RED_BRT;
          state_nxt     = S_DBRT;
        end
      end
      S_DBRT: begin
        if (sts.div_done) begin
          cmd.cap_brt   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_RED_MOD;
          state_nxt     = S_DMOD;
        end
      end
      S_DMOD: begin
        if (sts.div_done) begin
          cmd.cap_mod = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      default: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/triggered_hold_cooldown_sequencer.sv =====
// Millisecond-tick sequencer for a break-beam prop: armed (green breath),
// hold (magnet, tone schedule, red stutter) and cooldown (yellow flicker).
// Each input beat is one tick and yields exactly one result beat. Ticks are
// handled one at a time; the red ramp and stutter phase go through a single
// shared 32-step restoring divider: an armed or cooldown tick needs no
// division, a hold tick three, or one when the hold time is zero. The green
// breath position comes from a counter that follows the tick time, so it
// needs no division. A finished result sits in an output register, so the
// final output state only waits while that register is still full and not
// yet taken. Configuration writes take effect at once and belong between
// ticks.
module triggered_hold_cooldown_sequencer import thcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // beam_broken[0], flicker_level[8:1], flicker_dwell[15:9], chatter_hz[27:16]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // magnet_on[0], green_pwm[8:1], red_pwm[16:9], yellow_pwm[24:17],
  // tone_hz[36:25], phase_code[38:37]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_data
);

  thcs_cmd_t cmd;
  thcs_sts_t sts;

  thcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  thcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
